FILE: design/hkr_pkg.sv
// ----------------------------------------------------------------------------
// hkr_pkg: shared types and constants
// Payload structs, event kind codes, function codes and register indexes for
// the boot-keyboard report decoder.
// ----------------------------------------------------------------------------
package hkr_pkg;

    // Number of key slots carried by one input report.
    localparam int IN_SLOTS = 6;

    localparam logic FUNC_REPORT = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_REPEAT  = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_DELAY = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_PERIOD = 1'b1;

    localparam logic [15:0] INITIAL_DELAY_RESET = 16'd1000;
    localparam logic [15:0] REPEAT_PERIOD_RESET = 16'd250;

    typedef struct packed {
        logic       func;
        logic [7:0] modifier_byte;
        logic [7:0] slot_a;
        logic [7:0] slot_b;
        logic [7:0] slot_c;
        logic [7:0] slot_d;
        logic [7:0] slot_e;
        logic [7:0] slot_f;
        logic [9:0] elapsed_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [7:0] key_code;
        logic       shifted;
        logic       last_event;
    } out_item_t;

endpackage

FILE: design/hkr_front.sv
// ----------------------------------------------------------------------------
// hkr_front: report and tick classifier
// Accepts items, compares the new report with the held one, runs the repeat
// countdown and hands a job with the event masks to the queue.
// ----------------------------------------------------------------------------
module hkr_front
    import hkr_pkg::*;
#(
    parameter int KEY_SLOTS = 6,
    parameter int JOB_W     = 18 * KEY_SLOTS + 3
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   q_valid,
    input  logic                   q_ready,
    output logic [JOB_W-1:0]       q_job
);

    localparam int EW = 2 * KEY_SLOTS;

    logic [15:0] initial_delay_reg;
    logic [15:0] repeat_period_reg;
    logic [7:0]  held_mod_reg, held_mod_next;
    logic [7:0]  held_keys_reg [KEY_SLOTS];
    logic [7:0]  held_keys_next [KEY_SLOTS];
    logic [15:0] countdown_reg, countdown_next;

    logic [7:0]      in_slots [IN_SLOTS];
    logic [7:0]      fresh [KEY_SLOTS];
    logic [EW-1:0]   ev_mask;
    logic [8*EW-1:0] ev_keys;
    logic            hi_repeat, lo_sh, hi_sh;
    logic            fire, accept;
    logic            rel_found, press_found;

    assign in_slots[0] = s_data.slot_a;
    assign in_slots[1] = s_data.slot_b;
    assign in_slots[2] = s_data.slot_c;
    assign in_slots[3] = s_data.slot_d;
    assign in_slots[4] = s_data.slot_e;
    assign in_slots[5] = s_data.slot_f;

    assign s_ready = q_ready;
    assign accept  = s_valid && s_ready;
    assign fire    = countdown_reg <= {6'd0, s_data.elapsed_ms};

    always_comb begin
        ev_mask     = '0;
        ev_keys     = '0;
        hi_repeat   = 1'b0;
        lo_sh       = held_mod_reg != 8'd0;
        hi_sh       = 1'b0;
        rel_found   = 1'b0;
        press_found = 1'b0;
        held_mod_next  = held_mod_reg;
        countdown_next = countdown_reg;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            fresh[i] = 8'd0;
            for (int j = 0; j < IN_SLOTS; j++) begin
                if (i == j) begin
                    fresh[i] = in_slots[j];
                end
            end
            held_keys_next[i] = held_keys_reg[i];
        end

        if (s_data.func == FUNC_TICK) begin
            // Repeats of every held key, in slot order, when the countdown runs out.
            hi_repeat = 1'b1;
            hi_sh     = held_mod_reg != 8'd0;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                ev_mask[KEY_SLOTS+i]           = fire && (held_keys_reg[i] != 8'd0);
                ev_keys[8*(KEY_SLOTS+i) +: 8] = held_keys_reg[i];
            end
            countdown_next = fire ? repeat_period_reg
                                  : countdown_reg - {6'd0, s_data.elapsed_ms};
        end else begin
            hi_sh = s_data.modifier_byte != 8'd0;
            // Releases occupy the low half of the mask, presses the high half.
            for (int i = 0; i < KEY_SLOTS; i++) begin
                rel_found   = 1'b0;
                press_found = 1'b0;
                for (int j = 0; j < KEY_SLOTS; j++) begin
                    if (fresh[j] == held_keys_reg[i]) begin
                        rel_found = 1'b1;
                    end
                    if (held_keys_reg[j] == fresh[i]) begin
                        press_found = 1'b1;
                    end
                end
                ev_mask[i]           = (held_keys_reg[i] != 8'd0) && !rel_found;
                ev_keys[8*i +: 8]    = held_keys_reg[i];
                ev_mask[KEY_SLOTS+i] = (fresh[i] != 8'd0) && !press_found;
                ev_keys[8*(KEY_SLOTS+i) +: 8] = fresh[i];
                held_keys_next[i] = fresh[i];
            end
            held_mod_next = s_data.modifier_byte;
            if (ev_mask[EW-1:KEY_SLOTS] != '0) begin
                countdown_next = initial_delay_reg;
            end
        end
    end

    assign q_valid = accept && (ev_mask != '0);
    assign q_job   = {hi_sh, lo_sh, hi_repeat, ev_keys, ev_mask};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            initial_delay_reg <= INITIAL_DELAY_RESET;
            repeat_period_reg <= REPEAT_PERIOD_RESET;
            held_mod_reg      <= 8'd0;
            countdown_reg     <= 16'd0;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                held_keys_reg[i] <= 8'd0;
            end
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_INITIAL_DELAY: initial_delay_reg <= cfg_data;
                    CFG_REPEAT_PERIOD: repeat_period_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                held_mod_reg  <= held_mod_next;
                countdown_reg <= countdown_next;
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    held_keys_reg[i] <= held_keys_next[i];
                end
            end
        end
    end

endmodule

FILE: design/hkr_queue.sv
// ----------------------------------------------------------------------------
// hkr_queue: job queue
// A short first-in first-out queue of event jobs between the classifier and
// the event sequencer.
// ----------------------------------------------------------------------------
module hkr_queue
    import hkr_pkg::*;
#(
    parameter int WIDTH = 111,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wptr_reg, rptr_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign in_ready  = count_reg != CW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
        end
    end

endmodule

FILE: design/hkr_back.sv
// ----------------------------------------------------------------------------
// hkr_back: event sequencer
// Takes one job at a time and emits its events lowest bit first, one per
// cycle while m_ready allows, through an output register.
// ----------------------------------------------------------------------------
module hkr_back
    import hkr_pkg::*;
#(
    parameter int KEY_SLOTS = 6,
    parameter int JOB_W     = 18 * KEY_SLOTS + 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_ready,
    input  logic [JOB_W-1:0] q_job,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

    localparam int EW = 2 * KEY_SLOTS;
    localparam int IW = $clog2(EW);

    logic            busy_reg;
    logic [EW-1:0]   mask_reg;
    logic [8*EW-1:0] keys_reg;
    logic            hi_repeat_reg, lo_sh_reg, hi_sh_reg;
    logic            m_valid_reg;
    out_item_t       out_reg, out_next;

    logic [EW-1:0] pick, rest;
    logic [IW-1:0] idx;
    logic          advance, done, load, is_low;

    assign pick    = mask_reg & (~mask_reg + 1'b1);
    assign rest    = mask_reg & ~pick;
    assign advance = busy_reg && (!m_valid_reg || m_ready);
    assign done    = advance && (rest == '0);
    assign q_ready = !busy_reg || done;
    assign load    = q_valid && q_ready;

    always_comb begin
        idx = '0;
        for (int i = 0; i < EW; i++) begin
            if (pick[i]) begin
                idx = IW'(i);
            end
        end
    end

    assign is_low = int'(idx) < KEY_SLOTS;

    always_comb begin
        out_next.key_code   = keys_reg[8*idx +: 8];
        out_next.last_event = rest == '0;
        if (is_low) begin
            out_next.event_kind = KIND_RELEASE;
            out_next.shifted    = lo_sh_reg;
        end else begin
            out_next.event_kind = hi_repeat_reg ? KIND_REPEAT : KIND_PRESS;
            out_next.shifted    = hi_sh_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            mask_reg      <= q_job[EW-1:0];
            keys_reg      <= q_job[9*EW-1:EW];
            hi_repeat_reg <= q_job[9*EW];
            lo_sh_reg     <= q_job[9*EW+1];
            hi_sh_reg     <= q_job[9*EW+2];
        end else if (advance) begin
            mask_reg <= rest;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                busy_reg <= 1'b1;
            end else if (done) begin
                busy_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: design/hid_keyboard_report_to_key_events.sv
// ----------------------------------------------------------------------------
// hid_keyboard_report_to_key_events: boot-keyboard report decoder
// Turns keyboard reports and time ticks into press, release and repeat events.
//
//   Port group  Dir  Handshake         Payload
//   s_*         in   s_valid/s_ready   in_item_t (report or tick)
//   m_*         out  m_valid/m_ready   out_item_t (one key event)
//   cfg_*       in   cfg_we            cfg_index, cfg_data
//
// An accepted item's job passes the queue memory, the sequencer job registers
// and the output register before its first event is valid. Events, up to
// 2*KEY_SLOTS per item, leave one per cycle while m_ready allows.
// The job queue lets new items enter while events of earlier ones still drain
// or stall on m_ready; s_ready drops only while the queue is full.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module hid_keyboard_report_to_key_events
    import hkr_pkg::*;
#(
    parameter int KEY_SLOTS   = 6,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int JOB_W = 18 * KEY_SLOTS + 3;

    logic             fq_valid, fq_ready;
    logic [JOB_W-1:0] fq_job;
    logic             qb_valid, qb_ready;
    logic [JOB_W-1:0] qb_job;

    hkr_front #(
        .KEY_SLOTS (KEY_SLOTS),
        .JOB_W     (JOB_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_job     (fq_job)
    );

    hkr_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_job),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_job)
    );

    hkr_back #(
        .KEY_SLOTS (KEY_SLOTS),
        .JOB_W     (JOB_W)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_job   (qb_job),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // An empty slot never turns into an event.
    a_no_zero_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.key_code != 8'd0)
        else $error("event with an empty key code");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.event_kind != KIND_UNUSED)
        else $error("event with a reserved kind");

    // Jobs are only produced for accepted items, so the queue never overflows.
    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        fq_valid |-> fq_ready && s_valid)
        else $error("job pushed without room or without an item");

    // A tick never yields a release.
    a_tick_no_release: assert property (@(posedge aclk) disable iff (!aresetn)
        fq_valid && s_data.func == FUNC_TICK |-> fq_job[KEY_SLOTS-1:0] == '0)
        else $error("release produced by a tick");

endmodule
